/* rtl/core/met_pkg.sv */
// ----------------------------------------------------------------------------
// met_pkg
// Shared types, widths and constants of the Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package met_pkg;

  // Number formats.
  localparam int FRAC_BITS  = 28;
  localparam int MAX_DIM    = 4096;
  localparam int PIX_W      = 12;
  localparam int DIM_W      = 13;
  localparam int STEP_W     = 36;
  localparam int CTR_W      = 35;
  localparam int ITER_W     = 16;
  localparam int MSQ_W      = 61;

  // Width of |pixel offset| * pixel_step.
  localparam int OFS_W      = PIX_W + STEP_W;
  // Width of a mapped coordinate c (signed), with headroom for the center.
  localparam int C_W        = OFS_W + 2;
  // Width of a z component (signed). The escape test bounds |z| below 2^36.
  localparam int Z_W        = C_W + 1;
  // Multiplier operand: two digits of DIG_W bits.
  localparam int DIG_W      = 26;
  localparam int MAG_W      = 2 * DIG_W;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int MUL_STEPS  = 4;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
  // Sum of two squares before saturation.
  localparam int SUM_W      = MSQ_W + 1;

  // Escape threshold 65536 in fixed point, and the component bound it implies.
  localparam int ESC_SHIFT  = 16 + FRAC_BITS;
  localparam int Z_LIVE_W   = (ESC_SHIFT + FRAC_BITS) / 2;
  localparam logic [SUM_W-1:0] ESCAPE_LVL = SUM_W'(1) << ESC_SHIFT;
  localparam logic [MSQ_W-1:0] SQ_MAX     = {MSQ_W{1'b1}};
  localparam logic [DIM_W-1:0] DIM_CAP    = DIM_W'(MAX_DIM);

  // Item queue between front and back.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = STEP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_PIXEL_STEP   = 3'd2,
    CFG_CENTER_X     = 3'd3,
    CFG_CENTER_Y     = 3'd4,
    CFG_ITER_LIMIT   = 3'd5
  } cfg_idx_e;

  // Registers that set the mapping from pixel to complex plane.
  typedef struct packed {
    logic [DIM_W-1:0]         frame_width;
    logic [DIM_W-1:0]         frame_height;
    logic [STEP_W-1:0]        pixel_step;
    logic signed [CTR_W-1:0]  center_x;
    logic signed [CTR_W-1:0]  center_y;
  } map_cfg_t;

  // One queued item: the point c in the complex plane.
  typedef struct packed {
    logic signed [C_W-1:0] cx;
    logic signed [C_W-1:0] cy;
  } coord_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_STEP
  } back_state_e;

endpackage

/* rtl/core/mandelbrot_escape_time.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Mandelbrot escape-time evaluator: one pixel item in, one result item out.
// ----------------------------------------------------------------------------
// Each accepted pixel is mapped to c = (pixel - frame/2) * pixel_step + center,
// with the offsets and then the scaled offsets registered, and queued; the engine
// then iterates z = z^2 + c from zero until the iteration limit or
// |z|^2 >= 65536. Each iteration runs the two-digit 26x26 multipliers and then
// one update step; a pixel starts with one multiplier pass to clear z. The
// iteration limit defaults to 256, and a two-entry queue lets the next pixels
// be accepted while one is iterating; a result register lets the engine start
// the next pixel while a result waits to be taken. Configuration may be written
// only when no item is in work.
module mandelbrot_escape_time (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] iterations_o,
  output logic        inside_res_o,
  output logic [60:0] magnitude_sq_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [35:0] cfg_data_i
);
  import met_pkg::*;

  map_cfg_t          map_cfg_q;
  logic [ITER_W-1:0] limit_q;

  logic   push, full, pop, empty;
  coord_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cfg_q.frame_width  <= DIM_W'(640);
      map_cfg_q.frame_height <= DIM_W'(480);
      map_cfg_q.pixel_step   <= STEP_W'(1677722);
      map_cfg_q.center_x     <= '0;
      map_cfg_q.center_y     <= '0;
      limit_q                <= ITER_W'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  map_cfg_q.frame_width  <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: map_cfg_q.frame_height <= cfg_data_i[DIM_W-1:0];
        CFG_PIXEL_STEP:   map_cfg_q.pixel_step   <= cfg_data_i[STEP_W-1:0];
        CFG_CENTER_X:     map_cfg_q.center_x     <= $signed(cfg_data_i[CTR_W-1:0]);
        CFG_CENTER_Y:     map_cfg_q.center_y     <= $signed(cfg_data_i[CTR_W-1:0]);
        CFG_ITER_LIMIT:   limit_q                <= cfg_data_i[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  met_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (map_cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  met_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  met_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limit_i       (limit_q),
    .pop_o         (pop),
    .coord_i       (pop_data),
    .empty_i       (empty),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .iterations_o  (iterations_o),
    .inside_res_o  (inside_res_o),
    .magnitude_sq_o(magnitude_sq_o)
  );

endmodule

/* rtl/core/met_front.sv */
// ----------------------------------------------------------------------------
// met_front
// Accepts pixel items, maps them into the complex plane and pushes the point
// into the item queue.
// ----------------------------------------------------------------------------
module met_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  met_pkg::map_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [11:0]       pixel_x_i,
  input  logic [11:0]       pixel_y_i,
  output logic              push_o,
  output met_pkg::coord_t   push_data_o,
  input  logic              full_i
);
  import met_pkg::*;

  front_state_e state_q, state_d;

  logic [PIX_W-1:0] dx_mag_q, dy_mag_q;
  logic             dx_neg_q, dy_neg_q;
  logic [OFS_W-1:0] ox_q, oy_q;
  logic             accept;

  logic [PIX_W-1:0] dx_mag, dy_mag;
  logic             dx_neg, dy_neg;

  // Signed offset of a pixel from the frame middle, as magnitude and sign.
  function automatic logic [PIX_W:0] pix_offset(input logic [PIX_W-1:0] pix,
                                                input logic [DIM_W-1:0] frame);
    logic [DIM_W-1:0] f;
    logic [PIX_W:0]   d;
    logic [PIX_W:0]   m;
    f = (frame > DIM_CAP) ? DIM_CAP : frame;
    d = {1'b0, pix} - {1'b0, f[DIM_W-1:1]};
    m = d[PIX_W] ? -d : d;
    return {d[PIX_W], m[PIX_W-1:0]};
  endfunction

  // Apply the sign to the scaled offset and add the center.
  function automatic logic signed [C_W-1:0] to_plane(input logic [OFS_W-1:0] ofs,
                                                     input logic neg,
                                                     input logic signed [CTR_W-1:0] ctr);
    logic signed [C_W-1:0] p;
    p = $signed(C_W'(ofs));
    return (neg ? -p : p) + C_W'(ctr);
  endfunction

  assign {dx_neg, dx_mag} = pix_offset(pixel_x_i, cfg_i.frame_width);
  assign {dy_neg, dy_mag} = pix_offset(pixel_y_i, cfg_i.frame_height);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    push_o     = 1'b0;
    accept     = 1'b0;
    case (state_q)
      F_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          accept  = 1'b1;
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  // Offsets are captured on accept and scaled by the pixel step in the cycle after.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_mag_q <= dx_mag;
      dy_mag_q <= dy_mag;
      dx_neg_q <= dx_neg;
      dy_neg_q <= dy_neg;
    end
    if (state_q == F_MUL) begin
      ox_q <= OFS_W'(dx_mag_q) * OFS_W'(cfg_i.pixel_step);
      oy_q <= OFS_W'(dy_mag_q) * OFS_W'(cfg_i.pixel_step);
    end
  end

  assign push_data_o.cx = to_plane(ox_q, dx_neg_q, cfg_i.center_x);
  assign push_data_o.cy = to_plane(oy_q, dy_neg_q, cfg_i.center_y);

endmodule

/* rtl/core/met_fifo.sv */
// ----------------------------------------------------------------------------
// met_fifo
// Short item queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module met_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  met_pkg::coord_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output met_pkg::coord_t pop_data_o,
  output logic            empty_o
);
  import met_pkg::*;

  coord_t                 entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]    count_q;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = entry_q[rd_ptr_q];

endmodule

/* rtl/core/met_mul.sv */
// ----------------------------------------------------------------------------
// met_mul
// Unsigned multiplier of two-digit operands, one digit product per cycle.
// The product holds until the next start.
// ----------------------------------------------------------------------------
module met_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [met_pkg::MAG_W-1:0]    a_i,
  input  logic [met_pkg::MAG_W-1:0]    b_i,
  output logic [met_pkg::PROD_W-1:0]   prod_o,
  output logic                         last_o
);
  import met_pkg::*;

  logic                 busy_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [MAG_W-1:0]     a_q, b_q;
  logic [PROD_W-1:0]    acc_q;
  logic [DIG_W-1:0]     a_dig, b_dig;
  logic [MAG_W-1:0]     pp;
  logic [1:0]           dig_pos;

  // Digit selection: the high count bit walks a, the low bit walks b.
  assign a_dig   = a_q[DIG_W * cnt_q[1] +: DIG_W];
  assign b_dig   = b_q[DIG_W * cnt_q[0] +: DIG_W];
  assign pp      = MAG_W'(a_dig) * MAG_W'(b_dig);
  assign dig_pos = 2'(cnt_q[1]) + 2'(cnt_q[0]);
  assign last_o  = busy_q && (cnt_q == MUL_CNT_W'(MUL_STEPS - 1));
  assign prod_o  = acc_q;

  // Sequence control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= !last_o;
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + (PROD_W'(pp) << (DIG_W * int'(dig_pos)));
    end
  end

endmodule

/* rtl/core/met_back.sv */
// ----------------------------------------------------------------------------
// met_back
// Iteration engine: runs z = z^2 + c for one queued point at a time with
// three multipliers working in parallel, and holds the result item.
// ----------------------------------------------------------------------------
module met_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     limit_i,
  output logic            pop_o,
  input  met_pkg::coord_t coord_i,
  input  logic            empty_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [15:0]     iterations_o,
  output logic            inside_res_o,
  output logic [60:0]     magnitude_sq_o
);
  import met_pkg::*;

  back_state_e state_q, state_d;

  logic signed [C_W-1:0] cx_q, cy_q;
  logic signed [Z_W-1:0] zx_q, zy_q;
  logic [ITER_W-1:0]     iter_q;

  logic                  out_valid_q;
  logic [ITER_W-1:0]     iterations_q;
  logic                  inside_q;
  logic [MSQ_W-1:0]      msq_q;

  logic                  load_c, mul_start, mul_zero, step_en, load_out, slot_free;
  logic [PROD_W-1:0]     p_xy, p_xx, p_yy;
  logic                  last_xy, last_xx, last_yy, mul_last;
  logic [MSQ_W-1:0]      zx2, zy2, msq;
  logic [SUM_W-1:0]      sq_sum;
  logic                  run, neg;
  logic [MAG_W-1:0]      cur_x_mag, cur_y_mag;
  logic [Z_W-2:0]        xy_val;
  logic signed [Z_W-1:0] xy_s, zx_new, zy_new;
  logic [MAG_W-1:0]      op_x, op_y;

  // Square truncated by the fraction bits, saturated to the result width.
  function automatic logic [MSQ_W-1:0] sq_trunc(input logic [PROD_W-1:0] p);
    if (|p[PROD_W-1:FRAC_BITS+MSQ_W]) begin
      return SQ_MAX;
    end
    return p[FRAC_BITS +: MSQ_W];
  endfunction

  function automatic logic [MAG_W-1:0] z_mag(input logic signed [Z_W-1:0] v);
    logic [Z_W-1:0] t;
    t = v[Z_W-1] ? Z_W'(-v) : Z_W'(v);
    return MAG_W'(t);
  endfunction

  // Products of the current z: |zx*zy|, zx^2 and zy^2.
  assign zx2       = sq_trunc(p_xx);
  assign zy2       = sq_trunc(p_yy);
  assign sq_sum    = SUM_W'(zx2) + SUM_W'(zy2);
  assign msq       = (sq_sum > SUM_W'(SQ_MAX)) ? SQ_MAX : sq_sum[MSQ_W-1:0];
  assign run       = (iter_q < limit_i) && (sq_sum < ESCAPE_LVL);
  assign mul_last  = last_xy && last_xx && last_yy;
  assign cur_x_mag = z_mag(zx_q);
  assign cur_y_mag = z_mag(zy_q);

  // Next z. While the loop runs, |z| is small enough that nothing saturates.
  assign neg    = zx_q[Z_W-1] != zy_q[Z_W-1];
  assign xy_val = p_xy[FRAC_BITS-1 +: Z_W-1];
  assign xy_s   = $signed({1'b0, xy_val});
  assign zy_new = (neg ? -xy_s : xy_s) + Z_W'(cy_q);
  assign zx_new = $signed({1'b0, zx2[Z_W-2:0]}) - $signed({1'b0, zy2[Z_W-2:0]})
                  + Z_W'(cx_q);
  assign op_x   = mul_zero ? '0 : z_mag(zx_new);
  assign op_y   = mul_zero ? '0 : z_mag(zy_new);

  assign slot_free = !out_valid_q || !out_stall_i;

  met_mul u_mul_xy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (op_x),
    .b_i    (op_y),
    .prod_o (p_xy),
    .last_o (last_xy)
  );

  met_mul u_mul_xx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (op_x),
    .b_i    (op_x),
    .prod_o (p_xx),
    .last_o (last_xx)
  );

  met_mul u_mul_yy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (op_y),
    .b_i    (op_y),
    .prod_o (p_yy),
    .last_o (last_yy)
  );

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    load_c    = 1'b0;
    mul_start = 1'b0;
    mul_zero  = 1'b0;
    step_en   = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      B_IDLE: begin
        // A new point starts from z = 0, so all three products start at zero.
        if (!empty_i) begin
          pop_o     = 1'b1;
          load_c    = 1'b1;
          mul_start = 1'b1;
          mul_zero  = 1'b1;
          state_d   = B_MUL;
        end
      end
      B_MUL: begin
        if (mul_last) begin
          state_d = B_STEP;
        end
      end
      B_STEP: begin
        if (run) begin
          step_en   = 1'b1;
          mul_start = 1'b1;
          state_d   = B_MUL;
        end else if (slot_free) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // Iteration count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_c) begin
        iter_q <= '0;
      end else if (step_en) begin
        iter_q <= iter_q + 1'b1;
      end
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
    end
  end

  // Point, z and result payload.
  always_ff @(posedge clk_i) begin
    if (load_c) begin
      cx_q <= coord_i.cx;
      cy_q <= coord_i.cy;
      zx_q <= '0;
      zy_q <= '0;
    end else if (step_en) begin
      zx_q <= zx_new;
      zy_q <= zy_new;
    end
    if (load_out) begin
      iterations_q <= iter_q;
      inside_q     <= (iter_q == limit_i);
      msq_q        <= msq;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign iterations_o   = iterations_q;
  assign inside_res_o   = inside_q;
  assign magnitude_sq_o = msq_q;

`ifndef NO_ASSERTIONS
  // The count never passes the limit while a point is in work.
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != B_IDLE) |-> (iter_q <= limit_i))
    else $error("iteration count passed the limit");

  // A running loop implies |z| below the bound that keeps 2*zx*zy unsaturated.
  a_z_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_STEP && run) |->
      (cur_x_mag[MAG_W-1:Z_LIVE_W] == '0 && cur_y_mag[MAG_W-1:Z_LIVE_W] == '0))
    else $error("z component too large for a running iteration");

  // The multipliers finish only while the engine waits for them.
  a_mul_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_xy || last_xx || last_yy) |-> (mul_last && state_q == B_MUL))
    else $error("multiplier finished outside the wait state");

  // A result is written only into a free output slot.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> slot_free)
    else $error("result overwritten before it was taken");
`endif

endmodule
